// ----- rtl/core/image_row_column_projection_top_macros.svh -----
// Assertion macros shared by the projection RTL.
`ifndef IMAGE_ROW_COLUMN_PROJECTION_TOP_MACROS_SVH
`define IMAGE_ROW_COLUMN_PROJECTION_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define IPROJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that cons holds in the same cycle as ante.
`define IPROJ_ASSERT_IMPL(lbl, ante, cons, msg) \
  `IPROJ_ASSERT(lbl, (ante) |-> (cons), msg)

// Check that cons holds in the cycle after ante.
`define IPROJ_ASSERT_NEXT(lbl, ante, cons, msg) \
  `IPROJ_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- rtl/core/iproj_pkg.sv -----
// Types, constants and codes of the row and column projection block.
`default_nettype none

package iproj_pkg;

  localparam int PIX_W          = 8;
  localparam int POS_W          = 12;
  localparam int RED_W          = 22;
  localparam int CH_W           = 20;
  localparam int CFG_W          = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int QUEUE_DEPTH    = 4;
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int WIDTH_RST      = 640;
  localparam int HEIGHT_RST     = 480;
  localparam int TDATA_IN_W     = 24;
  localparam int TDATA_OUT_W    = 80;
  localparam int OUT_FIELDS_W   = POS_W + RED_W + 2 * CH_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MONO_MODE    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_COLUMN = 1'b0,
    KIND_ROW    = 1'b1
  } kind_e;

  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic             mono_mode;
  } cfg_t;

  typedef struct packed {
    logic [RED_W-1:0] red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } sums_t;

  typedef struct packed {
    logic [POS_W-1:0] col_pos;
    logic [POS_W-1:0] row_pos;
    sums_t            pix;
    sums_t            row;
    logic             first_row;
    logic             last_col;
    logic             last_row;
    logic             mono;
  } entry_t;

  typedef struct packed {
    kind_e            kind;
    logic [POS_W-1:0] index;
    sums_t            sums;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/iproj_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module iproj_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [W-1:0]                          wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [W-1:0]                          rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/iproj_front.sv -----
// Front end: pixel intake, contribution, position tracking and row sums.
`default_nettype none

module iproj_front #(
  parameter int MAX_WIDTH  = iproj_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = iproj_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire iproj_pkg::cfg_t              cfg_i,
  input  wire logic                         pix_valid_i,
  output logic                              pix_ready_o,
  input  wire logic [iproj_pkg::PIX_W-1:0]  pix_red_i,
  input  wire logic [iproj_pkg::PIX_W-1:0]  pix_green_i,
  input  wire logic [iproj_pkg::PIX_W-1:0]  pix_blue_i,
  input  wire logic                         full_i,
  output logic                              push_o,
  output iproj_pkg::entry_t                 entry_o
);

  localparam int WW = (iproj_pkg::CFG_W > $clog2(MAX_WIDTH + 1)) ?
                      iproj_pkg::CFG_W : $clog2(MAX_WIDTH + 1);
  localparam int HW = (iproj_pkg::CFG_W > $clog2(MAX_HEIGHT + 1)) ?
                      iproj_pkg::CFG_W : $clog2(MAX_HEIGHT + 1);

  logic [iproj_pkg::POS_W-1:0] col_pos_q, col_pos_d;
  logic [iproj_pkg::POS_W-1:0] row_pos_q, row_pos_d;
  iproj_pkg::sums_t            row_q, row_d;
  iproj_pkg::sums_t            pix;
  logic [WW-1:0]               w_ext, w_lim;
  logic [HW-1:0]               h_ext, h_lim;
  logic [iproj_pkg::PIX_W+1:0] mono_sum;
  logic                        last_col, last_row, first_col, push;

  assign pix_ready_o = !full_i;
  assign push        = pix_valid_i && !full_i;
  assign push_o      = push;

  always_comb begin
    w_ext = WW'(cfg_i.frame_width);
    if (w_ext == '0) begin
      w_lim = WW'(1);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = w_ext;
    end
    h_ext = HW'(cfg_i.frame_height);
    if (h_ext == '0) begin
      h_lim = HW'(1);
    end else if (h_ext > HW'(MAX_HEIGHT)) begin
      h_lim = HW'(MAX_HEIGHT);
    end else begin
      h_lim = h_ext;
    end
    last_col  = WW'(col_pos_q) >= (w_lim - WW'(1));
    last_row  = HW'(row_pos_q) >= (h_lim - HW'(1));
    first_col = (col_pos_q == '0);

    mono_sum = {2'b00, pix_red_i} + {2'b00, pix_green_i} + {2'b00, pix_blue_i};
    if (cfg_i.mono_mode) begin
      pix.red   = iproj_pkg::RED_W'(mono_sum);
      pix.green = '0;
      pix.blue  = '0;
    end else begin
      pix.red   = iproj_pkg::RED_W'(pix_red_i);
      pix.green = iproj_pkg::CH_W'(pix_green_i);
      pix.blue  = iproj_pkg::CH_W'(pix_blue_i);
    end

    if (first_col) begin
      row_d = pix;
    end else begin
      row_d.red   = row_q.red + pix.red;
      row_d.green = row_q.green + pix.green;
      row_d.blue  = row_q.blue + pix.blue;
    end

    if (last_col) begin
      col_pos_d = '0;
      row_pos_d = last_row ? '0 : row_pos_q + 1'b1;
    end else begin
      col_pos_d = col_pos_q + 1'b1;
      row_pos_d = row_pos_q;
    end

    entry_o.col_pos   = col_pos_q;
    entry_o.row_pos   = row_pos_q;
    entry_o.pix       = pix;
    entry_o.row       = row_d;
    entry_o.first_row = (row_pos_q == '0);
    entry_o.last_col  = last_col;
    entry_o.last_row  = last_row;
    entry_o.mono      = cfg_i.mono_mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
      row_q     <= '0;
    end else if (push) begin
      col_pos_q <= col_pos_d;
      row_pos_q <= row_pos_d;
      row_q     <= row_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/iproj_fifo.sv -----
// Short register queue between the front end and the column back end.
`default_nettype none

module iproj_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = iproj_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic      [W-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/iproj_back.sv -----
// Back end: column accumulation in RAM and result sequencing to the output.
`default_nettype none
`include "image_row_column_projection_top_macros.svh"

module iproj_back #(
  parameter int MAX_WIDTH = iproj_pkg::MAX_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              head_valid_i,
  input  wire iproj_pkg::entry_t head_i,
  output logic                   pop_o,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output iproj_pkg::result_t     res_o
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int XW = (iproj_pkg::POS_W > $clog2(MAX_WIDTH + 1)) ?
                      iproj_pkg::POS_W : $clog2(MAX_WIDTH + 1);
  localparam int SW = $bits(iproj_pkg::sums_t);

  function automatic logic [AW-1:0] col_addr(input logic [iproj_pkg::POS_W-1:0] pos);
    logic [XW-1:0] ext;
    ext = XW'(pos);
    if (ext >= XW'(MAX_WIDTH)) begin
      col_addr = AW'(MAX_WIDTH - 1);
    end else begin
      col_addr = ext[AW-1:0];
    end
  endfunction

  function automatic iproj_pkg::sums_t mask_mono(input iproj_pkg::sums_t s, input logic mono);
    iproj_pkg::sums_t m;
    m = s;
    if (mono) begin
      m.green = '0;
      m.blue  = '0;
    end
    mask_mono = m;
  endfunction

  iproj_pkg::entry_t  s1_q;
  logic               s1_valid_q;
  logic               fwd_q;
  iproj_pkg::sums_t   fwd_data_q;
  iproj_pkg::result_t cur_q, pend_q, col_res, row_res;
  logic               out_valid_q, pend_valid_q;
  iproj_pkg::sums_t   base, sum, ram_rdata;
  logic [SW-1:0]      ram_rdata_raw;
  logic [AW-1:0]      head_addr, s1_addr;
  logic               take, load_ok, needs_out, s1_adv, load, pop;

  assign head_addr = col_addr(head_i.col_pos);
  assign s1_addr   = col_addr(s1_q.col_pos);
  assign ram_rdata = iproj_pkg::sums_t'(ram_rdata_raw);

  iproj_ram #(
    .W    (SW),
    .DEPTH(MAX_WIDTH)
  ) u_col_ram (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_addr),
    .wdata_i(sum),
    .re_i   (pop),
    .raddr_i(head_addr),
    .rdata_o(ram_rdata_raw)
  );

  always_comb begin
    if (s1_q.first_row) begin
      base = '0;
    end else if (fwd_q) begin
      base = fwd_data_q;
    end else begin
      base = ram_rdata;
    end
    sum.red   = base.red + s1_q.pix.red;
    sum.green = base.green + s1_q.pix.green;
    sum.blue  = base.blue + s1_q.pix.blue;

    col_res.kind  = iproj_pkg::KIND_COLUMN;
    col_res.index = s1_q.col_pos;
    col_res.sums  = mask_mono(sum, s1_q.mono);
    col_res.last  = !s1_q.last_col;
    row_res.kind  = iproj_pkg::KIND_ROW;
    row_res.index = s1_q.row_pos;
    row_res.sums  = mask_mono(s1_q.row, s1_q.mono);
    row_res.last  = 1'b1;

    take      = out_valid_q && res_ready_i;
    load_ok   = !out_valid_q || (take && !pend_valid_q);
    needs_out = s1_q.last_row || s1_q.last_col;
    s1_adv    = s1_valid_q && (!needs_out || load_ok);
    load      = s1_adv && needs_out;
    pop       = head_valid_i && (!s1_valid_q || s1_adv);
  end

  assign pop_o       = pop;
  assign res_valid_o = out_valid_q;
  assign res_o       = cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      fwd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv && (s1_addr == head_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (load) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= s1_q.last_row && s1_q.last_col;
      end else if (take) begin
        if (pend_valid_q) begin
          pend_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_q       <= head_i;
      fwd_data_q <= sum;
    end
    if (load) begin
      cur_q  <= s1_q.last_row ? col_res : row_res;
      pend_q <= row_res;
    end else if (take && pend_valid_q) begin
      cur_q <= pend_q;
    end
  end

  `IPROJ_ASSERT(a_pend_needs_cur, !pend_valid_q || out_valid_q, "row result held without a shown result")
  `IPROJ_ASSERT_NEXT(a_column_first, s1_adv && s1_q.last_row && s1_q.last_col, pend_valid_q && cur_q.kind == iproj_pkg::KIND_COLUMN && pend_q.kind == iproj_pkg::KIND_ROW, "column result must precede row result")
  `IPROJ_ASSERT_IMPL(a_col_last, out_valid_q && cur_q.kind == iproj_pkg::KIND_COLUMN, cur_q.last == !pend_valid_q, "column last flag disagrees with pending row result")

endmodule

`default_nettype wire

// ----- rtl/core/image_row_column_projection_top.sv -----
// Top level of the row and column intensity projection block.
//
// Usage:
//   Pixels enter in raster order on the s_axis channel, one transfer per pixel.
//   Results leave on the m_axis channel: tuser gives the kind (column or row
//   sum), tlast marks the final result caused by a pixel. A pixel in the last
//   row yields its column sum; a pixel that ends a row yields the row sum,
//   after the column sum when both occur.
//   Frame width, frame height and mono mode are written on the cfg channel
//   while no pixel is in flight; cfg_ready_o is always high.
//   An accepted pixel passes the queue and the back-end stage register before its results are registered for output.
//   Throughput: one pixel per cycle while the receiver takes results, set by the single column RAM
//   read-modify-write per pixel; the pixel ending the last row of a frame
//   yields two results, sent one after the other.
//   A four-entry queue parts the pixel front end from the column back end, so
//   pixels keep flowing while the receiver stalls until the queue fills; after
//   that s_axis_tready drops until results are taken again.
//   Reset clears positions, row sums and the queue and loads the default
//   configuration; column RAM needs no clearing, the first row of each frame
//   overwrites every entry it later reads.
`default_nettype none

module image_row_column_projection_top #(
  parameter int MAX_WIDTH  = iproj_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = iproj_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // cfg channel
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [iproj_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [iproj_pkg::CFG_W-1:0]          cfg_data_i,
  // pixel channel
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // tdata: pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16]
  input  wire logic [iproj_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
  // result channel
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // tdata: profile_index[11:0], total_red[33:12], total_green[53:34],
  //        total_blue[73:54], zero fill[79:74]
  output logic      [iproj_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
  // tuser: profile_kind[0]
  output logic                                      m_axis_tuser,
  output logic                                      m_axis_tlast
);

  iproj_pkg::cfg_t    cfg_q;
  iproj_pkg::entry_t  front_entry, head_entry;
  logic [$bits(iproj_pkg::entry_t)-1:0] head_raw;
  iproj_pkg::result_t res;
  logic               push, full, head_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= iproj_pkg::CFG_W'(iproj_pkg::WIDTH_RST);
      cfg_q.frame_height <= iproj_pkg::CFG_W'(iproj_pkg::HEIGHT_RST);
      cfg_q.mono_mode    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        iproj_pkg::CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i;
        iproj_pkg::CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i;
        iproj_pkg::CFG_MONO_MODE:    cfg_q.mono_mode    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  iproj_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pix_valid_i(s_axis_tvalid),
    .pix_ready_o(s_axis_tready),
    .pix_red_i  (s_axis_tdata[7:0]),
    .pix_green_i(s_axis_tdata[15:8]),
    .pix_blue_i (s_axis_tdata[23:16]),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (front_entry)
  );

  iproj_fifo #(
    .W    ($bits(iproj_pkg::entry_t)),
    .DEPTH(iproj_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_entry),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .data_o (head_raw)
  );

  assign head_entry = iproj_pkg::entry_t'(head_raw);

  iproj_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head_entry),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {{(iproj_pkg::TDATA_OUT_W - iproj_pkg::OUT_FIELDS_W){1'b0}},
                         res.sums.blue, res.sums.green, res.sums.red, res.index};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ----- tb/sv/tb_image_row_column_projection_top.sv -----
// Self-checking testbench: random and directed pixel frames against a profile predictor.
module tb_image_row_column_projection_top;
  timeunit 1ns;
  timeprecision 1ps;
  import iproj_pkg::*;

  class profile_checker;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             mono_reg;
    logic [RED_W-1:0] col_red   [MAX_WIDTH_DEF];
    logic [CH_W-1:0]  col_green [MAX_WIDTH_DEF];
    logic [CH_W-1:0]  col_blue  [MAX_WIDTH_DEF];
    bit               col_written [MAX_WIDTH_DEF];
    sums_t            row_sum;
    logic [POS_W-1:0] col_pos;
    logic [POS_W-1:0] row_pos;
    result_t          expected_q [$];
    int               mismatches;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      mono_reg   = 1'b0;
      row_sum    = '0;
      col_pos    = '0;
      row_pos    = '0;
      mismatches = 0;
      foreach (col_red[i]) begin
        col_red[i]     = '0;
        col_green[i]   = '0;
        col_blue[i]    = '0;
        col_written[i] = 1'b0;
      end
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg = val;
        CFG_FRAME_HEIGHT: height_reg = val;
        CFG_MONO_MODE:    mono_reg = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned span(logic [CFG_W-1:0] val, int unsigned top);
      if (val == 0) return 1;
      if (val > top) return top;
      return val;
    endfunction

    // A wider frame is safe only if every column it can read holds a sum.
    function bit width_ok(logic [CFG_W-1:0] val);
      int unsigned last;
      if (row_pos == 0) return 1'b1;
      last = span(val, MAX_WIDTH_DEF) - 1;
      if (col_pos > last) last = col_pos;
      for (int c = 0; c <= last; c++) begin
        if (!col_written[c]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void push(kind_e kind, logic [POS_W-1:0] idx, sums_t s, logic last);
      result_t res;
      res.kind       = kind;
      res.index      = idx;
      res.sums.red   = s.red;
      res.sums.green = mono_reg ? '0 : s.green;
      res.sums.blue  = mono_reg ? '0 : s.blue;
      res.last       = last;
      expected_q     = {expected_q, res};
    endfunction

    function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
      sums_t add;
      sums_t col_sum;
      bit    last_col;
      bit    last_row;
      if (mono_reg) begin
        add.red   = RED_W'(r) + RED_W'(g) + RED_W'(b);
        add.green = '0;
        add.blue  = '0;
      end else begin
        add.red   = RED_W'(r);
        add.green = CH_W'(g);
        add.blue  = CH_W'(b);
      end
      last_col = col_pos >= span(width_reg, MAX_WIDTH_DEF) - 1;
      last_row = row_pos >= span(height_reg, MAX_HEIGHT_DEF) - 1;
      col_sum = add;
      if (row_pos != 0) begin
        col_sum.red   = col_red[col_pos] + add.red;
        col_sum.green = col_green[col_pos] + add.green;
        col_sum.blue  = col_blue[col_pos] + add.blue;
      end
      col_red[col_pos]     = col_sum.red;
      col_green[col_pos]   = col_sum.green;
      col_blue[col_pos]    = col_sum.blue;
      col_written[col_pos] = 1'b1;
      if (col_pos == 0) begin
        row_sum = add;
      end else begin
        row_sum.red   = row_sum.red + add.red;
        row_sum.green = row_sum.green + add.green;
        row_sum.blue  = row_sum.blue + add.blue;
      end
      if (last_row) push(KIND_COLUMN, col_pos, col_sum, !last_col);
      if (last_col) begin
        push(KIND_ROW, row_pos, row_sum, 1'b1);
        col_pos = '0;
        row_pos = last_row ? '0 : row_pos + 1'b1;
      end else begin
        col_pos = col_pos + 1'b1;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d index %0d sums %0d/%0d/%0d last %0b",
                   got.kind, got.index, got.sums.red, got.sums.green, got.sums.blue,
                   got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.index !== want.index ||
          got.sums.red !== want.sums.red || got.sums.green !== want.sums.green ||
          got.sums.blue !== want.sums.blue || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected kind %0d index %0d sums %0d/%0d/%0d last %0b",
                   want.kind, want.index, want.sums.red, want.sums.green, want.sums.blue,
                   want.last);
          $display("          actual   kind %0d index %0d sums %0d/%0d/%0d last %0b",
                   got.kind, got.index, got.sums.red, got.sums.green, got.sums.blue,
                   got.last);
        end
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  logic                   s_ready_q;
  logic                   cfg_ready_q;
  logic                   m_valid_q;
  logic                   m_ready_q;
  logic [TDATA_OUT_W-1:0] m_data_q;
  logic                   m_user_q;
  logic                   m_last_q;

  bit             steady;
  profile_checker profiles = new();

  image_row_column_projection_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Sample mid-cycle so the edge sees settled values.
  always @(negedge clk_i) begin
    s_ready_q   = s_axis_tready;
    cfg_ready_q = cfg_ready_o;
    m_valid_q   = m_axis_tvalid;
    m_ready_q   = m_axis_tready;
    m_data_q    = m_axis_tdata;
    m_user_q    = m_axis_tuser;
    m_last_q    = m_axis_tlast;
  end

  initial begin
    result_t got;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_valid_q && m_ready_q) begin
        got.kind       = kind_e'(m_user_q);
        got.index      = m_data_q[POS_W-1:0];
        got.sums.red   = m_data_q[POS_W +: RED_W];
        got.sums.green = m_data_q[POS_W+RED_W +: CH_W];
        got.sums.blue  = m_data_q[POS_W+RED_W+CH_W +: CH_W];
        got.last       = m_last_q;
        profiles.check_result(got);
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 23);
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
    if (!steady && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk_i); while (!s_ready_q);
    profiles.note_pixel(r, g, b);
  endtask

  function automatic logic [PIX_W-1:0] channel_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random();
    send_pixel(channel_value(), channel_value(), channel_value());
  endtask

  // Hold input until every expected result has drained, then let the pipeline empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (profiles.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_q);
    profiles.write_reg(idx, val);
  endtask

  task automatic configure(int w, int h, int m);
    settle();
    if (w >= 0) write_cfg(CFG_FRAME_WIDTH, w[CFG_W-1:0]);
    if (h >= 0) write_cfg(CFG_FRAME_HEIGHT, h[CFG_W-1:0]);
    if (m >= 0) write_cfg(CFG_MONO_MODE, m[CFG_W-1:0]);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int pick_width();
    case ($urandom_range(19))
      0:       return 0;
      1:       return $urandom_range(4097, 8191);
      2, 3:    return $urandom_range(9, 64);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic int pick_height();
    case ($urandom_range(19))
      0:       return 0;
      1:       return $urandom_range(4096, 8191);
      2, 3:    return $urandom_range(7, 30);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  initial begin
    int sent;
    int phase_no;
    int w;
    int h;
    int m;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_FRAME_WIDTH;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    steady        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one colour frame of 3x2 with channel extremes
    configure(3, 2, 0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd170);
    // mono frame at full scale
    configure(2, 2, 1);
    repeat (4) send_pixel(8'd255, 8'd255, 8'd255);
    // zero sizes count as one
    configure(0, 0, 0);
    send_pixel(8'd255, 8'd1, 8'd128);
    send_pixel(8'd1, 8'd128, 8'd255);
    // oversized frame, then shrink it mid-row and mid-frame
    configure(8191, 8191, -1);
    repeat (5) send_random();
    configure(2, 3, -1);
    repeat (4) send_random();
    // mode switch mid-frame
    configure(-1, -1, 1);
    repeat (2) send_random();
    // start a full-width row
    configure(4096, 1, 0);
    repeat (40) send_random();

    sent = 0;
    phase_no = 0;
    while (sent < 1790) begin
      w = -1;
      h = -1;
      m = -1;
      if ($urandom_range(1)) begin
        w = pick_width();
        if (!profiles.width_ok(w[CFG_W-1:0])) w = -1;
      end
      if ($urandom_range(1)) h = pick_height();
      if ($urandom_range(2) == 0) m = $urandom_range(1);
      configure(w, h, m);
      steady = (phase_no >= 25 && phase_no < 40);
      repeat ($urandom_range(1, 40)) begin
        send_random();
        sent++;
      end
      phase_no++;
    end

    steady = 1'b0;
    settle();
    if (profiles.mismatches == 0 && profiles.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
